// ===== hw/rtl/pcau_pkg.sv =====
package pcau_pkg;

  localparam int ITER_STAGES = 4;
  localparam int LANE_DEPTH  = ITER_STAGES + 2;

  localparam logic [2:0]  CC_RESET        = 3'd3;
  localparam logic [2:0]  ALPHA_CHANNELS  = 3'd4;
  localparam logic        REG_CHANNEL_CNT = 1'b0;
  localparam logic [16:0] MAG_SAT_LIMIT   = 17'd65025;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_MAG = 3'd4
  } pcau_func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  simple;
    logic [15:0] sq;
    logic        sat;
    logic [7:0]  drem;
    logic [7:0]  quo;
    logic [8:0]  srem;
    logic [7:0]  root;
  } pcau_iter_t;

  typedef struct packed {
    logic [LANE_DEPTH:0]   load;
    logic [LANE_DEPTH-1:0] valid;
    logic                  out_valid;
  } pcau_flow_t;

  // One restoring divide step on bit idx of a and one digit-by-digit square root step on bit pair idx of sq.
  function automatic pcau_iter_t iter_step(input pcau_iter_t st, input logic [2:0] idx);
    pcau_iter_t  nx;
    logic [8:0]  dr;
    logic [8:0]  dd;
    logic [3:0]  pos;
    logic [10:0] sr;
    logic [10:0] trial;
    logic [10:0] sd;
    nx = st;
    dr = {st.drem, st.a[idx]};
    dd = dr - {1'b0, st.b};
    if (dr >= {1'b0, st.b}) begin
      nx.drem = dd[7:0];
      nx.quo  = {st.quo[6:0], 1'b1};
    end else begin
      nx.drem = dr[7:0];
      nx.quo  = {st.quo[6:0], 1'b0};
    end
    pos   = {idx, 1'b0};
    sr    = {st.srem, st.sq[pos + 4'd1], st.sq[pos]};
    trial = {1'b0, st.root, 2'b01};
    sd    = sr - trial;
    if (sr >= trial) begin
      nx.srem = sd[8:0];
      nx.root = {st.root[6:0], 1'b1};
    end else begin
      nx.srem = sr[8:0];
      nx.root = {st.root[6:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

// ===== hw/rtl/pcau_lane.sv =====
module pcau_lane (
  input  logic                            clk_i,
  input  logic [pcau_pkg::LANE_DEPTH-1:0] load_i,
  input  logic [2:0]                      func_i,
  input  logic [7:0]                      a_i,
  input  logic [7:0]                      b_i,
  output logic [7:0]                      res_o
);

  logic [2:0]  f1_q;
  logic [7:0]  a1_q;
  logic [7:0]  b1_q;
  logic [15:0] aa1_q;
  logic [15:0] bb1_q;
  logic [15:0] ab1_q;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      f1_q  <= func_i;
      a1_q  <= a_i;
      b1_q  <= b_i;
      aa1_q <= {8'd0, a_i} * {8'd0, a_i};
      bb1_q <= {8'd0, b_i} * {8'd0, b_i};
      ab1_q <= {8'd0, a_i} * {8'd0, b_i};
    end
  end

  logic [8:0]          sum9;
  logic [8:0]          diff9;
  logic [16:0]         sq17;
  logic [7:0]          simple;
  pcau_pkg::pcau_iter_t st_d;
  pcau_pkg::pcau_iter_t st_q [pcau_pkg::ITER_STAGES+1];

  always_comb begin
    sum9  = {1'b0, a1_q} + {1'b0, b1_q};
    diff9 = {1'b0, a1_q} - {1'b0, b1_q};
    sq17  = {1'b0, aa1_q} + {1'b0, bb1_q};
    case (f1_q)
      pcau_pkg::FUNC_ADD: simple = sum9[8] ? 8'hFF : sum9[7:0];
      pcau_pkg::FUNC_SUB: simple = diff9[8] ? 8'h00 : diff9[7:0];
      pcau_pkg::FUNC_MUL: simple = (ab1_q > 16'd255) ? 8'hFF : ab1_q[7:0];
      default:            simple = 8'h00;
    endcase
    st_d        = '0;
    st_d.func   = f1_q;
    st_d.a      = a1_q;
    st_d.b      = b1_q;
    st_d.simple = simple;
    st_d.sq     = sq17[15:0];
    st_d.sat    = (sq17 >= pcau_pkg::MAG_SAT_LIMIT);
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      st_q[0] <= st_d;
    end
  end

  for (genvar k = 1; k <= pcau_pkg::ITER_STAGES; k++) begin : g_iter
    localparam logic [2:0] HiBit = 3'(9 - 2 * k);
    pcau_pkg::pcau_iter_t mid;
    pcau_pkg::pcau_iter_t nxt;

    always_comb begin
      mid = pcau_pkg::iter_step(st_q[k-1], HiBit);
      nxt = pcau_pkg::iter_step(mid, HiBit - 3'd1);
    end

    always_ff @(posedge clk_i) begin
      if (load_i[k+1]) begin
        st_q[k] <= nxt;
      end
    end
  end

  pcau_pkg::pcau_iter_t last;

  always_comb begin
    last = st_q[pcau_pkg::ITER_STAGES];
    case (last.func)
      pcau_pkg::FUNC_DIV: res_o = (last.b == 8'h00) ? last.a : last.quo;
      pcau_pkg::FUNC_MAG: res_o = last.sat ? 8'hFF : last.root;
      default:            res_o = last.simple;
    endcase
  end

endmodule

// ===== hw/rtl/pcau_flow.sv =====
module pcau_flow (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output pcau_pkg::pcau_flow_t flow_o
);

  localparam int Depth = pcau_pkg::LANE_DEPTH;

  logic [Depth-1:0] valid_d;
  logic [Depth-1:0] valid_q;
  logic             out_valid_d;
  logic             out_valid_q;
  logic [Depth:0]   load;

  always_comb begin
    load[Depth] = !out_valid_q || out_ready_i;
    for (int k = Depth - 1; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < Depth; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
    out_valid_d = load[Depth] ? valid_q[Depth-1] : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign flow_o.load      = load;
  assign flow_o.valid     = valid_q;
  assign flow_o.out_valid = out_valid_q;

endmodule

// ===== hw/rtl/pixel_channel_arithmetic_unit.sv =====
// Throughput: one word per cycle unless m_axis_tready holds the output; each color lane is a
// 6-stage pipeline ahead of the output register, and its divider and square root resolve
// two bits per stage over four stages.
// Reset empties the pipeline and sets channel_count to 3; the data path has no reset.
module pixel_channel_arithmetic_unit #(
  parameter int COLOR_LANES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func, a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, zero padding.
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha.
  output logic [31:0] m_axis_tdata
);

  localparam int NumLanes = (COLOR_LANES > 3) ? 3 : COLOR_LANES;
  localparam int Depth    = pcau_pkg::LANE_DEPTH;

  pcau_pkg::pcau_flow_t flow;

  pcau_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .flow_o      (flow)
  );

  assign s_axis_tready = flow.load[0];
  assign m_axis_tvalid = flow.out_valid;
  assign pready        = 1'b1;

  logic [2:0] cc_q;
  logic       cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr[2] == pcau_pkg::REG_CHANNEL_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= pcau_pkg::CC_RESET;
    end else if (cfg_we) begin
      cc_q <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == pcau_pkg::REG_CHANNEL_CNT) ? {29'd0, cc_q} : 32'd0;

  logic [7:0] a_byte [3];
  logic [7:0] b_byte [3];
  logic [7:0] lane_res [3];

  assign a_byte[0] = s_axis_tdata[10:3];
  assign a_byte[1] = s_axis_tdata[18:11];
  assign a_byte[2] = s_axis_tdata[26:19];
  assign b_byte[0] = s_axis_tdata[42:35];
  assign b_byte[1] = s_axis_tdata[50:43];
  assign b_byte[2] = s_axis_tdata[58:51];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    if (i < NumLanes) begin : g_on
      pcau_lane u_lane (
        .clk_i  (clk_i),
        .load_i (flow.load[Depth-1:0]),
        .func_i (s_axis_tdata[2:0]),
        .a_i    (a_byte[i]),
        .b_i    (b_byte[i]),
        .res_o  (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = 8'h00;
    end
  end

  logic [7:0] alpha_in;
  logic [7:0] alpha_q [Depth];

  assign alpha_in = (cc_q == pcau_pkg::ALPHA_CHANNELS) ? s_axis_tdata[34:27] : 8'h00;

  always_ff @(posedge clk_i) begin
    if (flow.load[0]) begin
      alpha_q[0] <= alpha_in;
    end
    for (int k = 1; k < Depth; k++) begin
      if (flow.load[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  logic [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (flow.load[Depth]) begin
      out_q <= {alpha_q[Depth-1], lane_res[2], lane_res[1], lane_res[0]};
    end
  end

  assign m_axis_tdata = out_q;

  a_full_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flow.out_valid && (&flow.valid) && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while every stage is full and stalled");

  a_empty_output_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flow.out_valid |-> s_axis_tready)
    else $error("input refused while output register is empty");

  a_output_leaves_on_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("output word dropped without a handshake");

  a_stage_valid_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flow.valid[Depth-1] && flow.load[Depth]) |=> m_axis_tvalid)
    else $error("word in last stage lost on its way to the output");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLOR_LANES = 3;
  localparam int LATENCY = 6;
  localparam int PHASE_WORDS = 243;
  localparam int NUM_PHASES = 8;
  localparam logic [2:0] CC_ADDR = 3'(4 * pcau_pkg::REG_CHANNEL_CNT);

  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] b_blue;
    logic [7:0] b_green;
    logic [7:0] b_red;
    logic [7:0] a_alpha;
    logic [7:0] a_blue;
    logic [7:0] a_green;
    logic [7:0] a_red;
    logic [2:0] func;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_out_t;

  class pixel_scoreboard;
    logic [2:0] channel_count = pcau_pkg::CC_RESET;
    pixel_out_t expected_q[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;

    function logic [7:0] lane_result(logic [2:0] f, logic [7:0] a, logic [7:0] b);
      int unsigned x, y, r;
      x = a;
      y = b;
      case (pcau_pkg::pcau_func_e'(f))
        pcau_pkg::FUNC_ADD: r = (x + y > 255) ? 255 : x + y;
        pcau_pkg::FUNC_SUB: r = (x > y) ? x - y : 0;
        pcau_pkg::FUNC_MUL: r = (x * y > 255) ? 255 : x * y;
        pcau_pkg::FUNC_DIV: r = (y == 0) ? x : x / y;
        pcau_pkg::FUNC_MAG: begin
          r = 0;
          while (r < 255 && (r + 1) * (r + 1) <= x * x + y * y) r++;
        end
        default: r = 0;
      endcase
      return r[7:0];
    endfunction

    function void note_pixel(pixel_pair_t p);
      pixel_out_t e;
      e.red   = (COLOR_LANES > 0) ? lane_result(p.func, p.a_red, p.b_red) : 8'd0;
      e.green = (COLOR_LANES > 1) ? lane_result(p.func, p.a_green, p.b_green) : 8'd0;
      e.blue  = (COLOR_LANES > 2) ? lane_result(p.func, p.a_blue, p.b_blue) : 8'd0;
      e.alpha = (channel_count == pcau_pkg::ALPHA_CHANNELS) ? p.a_alpha : 8'd0;
      expected_q.push_back(e);
      words_in++;
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      string field_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};
      words_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: word %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (want[8*k +: 8] !== got[8*k +: 8]) begin
          $display("%0t: %s expected %0d, actual %0d", $time, field_name[k],
                   want[8*k +: 8], got[8*k +: 8]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_valid = 1'b0;
  logic s_axis_tready;
  pixel_pair_t s_data = '0;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [31:0] m_axis_tdata;

  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;

  pixel_scoreboard sb = new;

  pixel_channel_arithmetic_unit #(
    .COLOR_LANES(COLOR_LANES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready) sb.note_pixel(s_data);
      if (m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  function automatic pixel_pair_t make_pixel(logic [2:0] f, logic [7:0] ar, logic [7:0] ag,
                                             logic [7:0] ab, logic [7:0] aa, logic [7:0] br,
                                             logic [7:0] bg, logic [7:0] bb);
    pixel_pair_t p;
    p = '0;
    p.func = f;
    p.a_red = ar;
    p.a_green = ag;
    p.a_blue = ab;
    p.a_alpha = aa;
    p.b_red = br;
    p.b_green = bg;
    p.b_blue = bb;
    return p;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t rand_pixel();
    logic [2:0] f;
    f = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
    return make_pixel(f, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                      rand_byte(), rand_byte(), rand_byte());
  endfunction

  task automatic send_pixel(input pixel_pair_t p);
    while ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= p;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    int n = 0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic write_channel_count(input logic [2:0] cc);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CC_ADDR;
    pwdata <= {29'($urandom), cc};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.channel_count = cc;
    @(posedge clk_i);
  endtask

  task automatic check_channel_count();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CC_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[2:0] !== sb.channel_count) begin
      $display("%0t: channel_count read expected %0d, actual %0d", $time,
               sb.channel_count, prdata[2:0]);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    pixel_pair_t directed_q[$];
    logic [2:0] cc_plan[NUM_PHASES];
    cc_plan = '{pcau_pkg::ALPHA_CHANNELS, pcau_pkg::CC_RESET, 3'd0, 3'd7,
                pcau_pkg::ALPHA_CHANNELS, 3'd5, 3'd1, pcau_pkg::CC_RESET};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_channel_count();

    for (int f = pcau_pkg::FUNC_ADD; f <= pcau_pkg::FUNC_MAG; f++) begin
      directed_q.push_back(make_pixel(3'(f), 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(make_pixel(3'(f), 255, 255, 255, 255, 255, 255, 255));
      directed_q.push_back(make_pixel(3'(f), 255, 0, 200, 128, 0, 255, 1));
    end
    directed_q.push_back(make_pixel(pcau_pkg::FUNC_MAG, 3, 180, 179, 7, 4, 180, 180));
    directed_q.push_back(make_pixel(pcau_pkg::FUNC_DIV, 7, 100, 1, 9, 0, 7, 254));
    for (int f = 5; f <= 7; f++) begin
      directed_q.push_back(make_pixel(3'(f), 255, 255, 255, 255, 255, 255, 255));
    end
    foreach (directed_q[i]) send_pixel(directed_q[i]);
    s_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_channel_count(cc_plan[ph]);
      check_channel_count();
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 49; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 49; end
        default: begin send_idle = 6; recv_stall = 6; end
      endcase
      if (ph == 0) hold_left = 300;
      repeat (PHASE_WORDS) send_pixel(rand_pixel());
      s_valid <= 1'b0;
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end
    $display("Sent %0d pixel words and checked %0d results over all five operations,",
             sb.words_in, sb.words_out);
    $display("unused selectors, eight channel_count settings, idle and stall mixes and a long hold.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
